>>> sv/tsg_pkg.sv
`default_nettype none

package tsg_pkg;

   // Coordinate and register widths
   localparam int unsigned CoordWidth  = 12;
   localparam int unsigned TravelWidth = 13;
   localparam int unsigned ScreenWidth = 13;
   localparam int unsigned LimitWidth  = 12;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDataWidth = 13;

   // Register indexes
   localparam logic [CsrIdxWidth-1:0] CsrScreenWidth  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrScreenHeight = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrMaxJump      = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CsrSwipeMin     = 2'd3;

   // Register reset values
   localparam logic [ScreenWidth-1:0] ScreenWidthReset  = 13'd240;
   localparam logic [ScreenWidth-1:0] ScreenHeightReset = 13'd240;
   localparam logic [LimitWidth-1:0]  MaxJumpReset      = 12'd40;
   localparam logic [LimitWidth-1:0]  SwipeMinReset     = 12'd30;

   // Report classes
   localparam logic [1:0] ClassFailed = 2'd0;
   localparam logic [1:0] ClassUp     = 2'd1;
   localparam logic [1:0] ClassDown   = 2'd2;

   // Gesture codes
   localparam logic [2:0] GestNone  = 3'd0;
   localparam logic [2:0] GestTap   = 3'd1;
   localparam logic [2:0] GestUp    = 3'd2;
   localparam logic [2:0] GestDown  = 3'd3;
   localparam logic [2:0] GestLeft  = 3'd4;
   localparam logic [2:0] GestRight = 3'd5;

   // Largest finger count that still counts as a touch
   localparam logic [7:0] MaxFingers = 8'd2;

   typedef struct packed {
      logic [1:0] sample_class;
      logic [2:0] gesture;
   } rsp_word_type;

   // Magnitude of a signed travel; -4096 never occurs
   function automatic logic [CoordWidth-1:0] mag(input logic signed [TravelWidth-1:0] v);
      logic signed [TravelWidth-1:0] neg;
      neg = -v;
      return v[TravelWidth-1] ? neg[CoordWidth-1:0] : v[CoordWidth-1:0];
   endfunction

endpackage

`default_nettype wire

>>> sv/tsg_req_if.sv
`default_nettype none

interface tsg_req_if;
   logic       valid;
   logic       ready;
   logic       bus_ok;
   logic [7:0] finger_byte;
   logic [7:0] x_high_byte;
   logic [7:0] x_low_byte;
   logic [7:0] y_high_byte;
   logic [7:0] y_low_byte;

   modport source (
      output valid, bus_ok, finger_byte, x_high_byte, x_low_byte, y_high_byte, y_low_byte,
      input  ready
   );
   modport sink (
      input  valid, bus_ok, finger_byte, x_high_byte, x_low_byte, y_high_byte, y_low_byte,
      output ready
   );
endinterface

`default_nettype wire

>>> sv/tsg_rsp_if.sv
`default_nettype none

interface tsg_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] sample_class;
   logic [2:0] gesture;

   modport source (
      output valid, sample_class, gesture,
      input  ready
   );
   modport sink (
      input  valid, sample_class, gesture,
      output ready
   );
endinterface

`default_nettype wire

>>> sv/touch_swipe_gesture_recognizer_unit.sv
`default_nettype none

// Channel   Dir  Handshake          Word
// req_chan  in   valid/ready        bus_ok, finger_byte, x/y high and low bytes
// rsp_chan  out  valid/ready        sample_class, gesture
// csr_*     in   csr_we (no ready)  csr_index, csr_wdata
//
// One report per cycle while req_chan.ready is high: each accepted report is classified
// and the stroke updated in the same cycle; the word is registered (output or skid).
// The output register is backed by a one-word skid register, so req_chan.ready is
// registered and stays high while one finished word waits on a stalled sink.
// Reset is synchronous and active high; it clears the stroke and loads register defaults.
module touch_swipe_gesture_recognizer_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   tsg_req_if.sink                                 req_chan,
   tsg_rsp_if.source                               rsp_chan,
   input  wire logic                               csr_we,
   input  wire logic [tsg_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [tsg_pkg::CsrDataWidth-1:0]   csr_wdata
);

   // Configuration registers
   logic [tsg_pkg::ScreenWidth-1:0] scr_w_ff, scr_h_ff;
   logic [tsg_pkg::LimitWidth-1:0]  max_jump_ff, swipe_min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff     <= tsg_pkg::ScreenWidthReset;
         scr_h_ff     <= tsg_pkg::ScreenHeightReset;
         max_jump_ff  <= tsg_pkg::MaxJumpReset;
         swipe_min_ff <= tsg_pkg::SwipeMinReset;
      end else if (csr_we) begin
         case (csr_index)
            tsg_pkg::CsrScreenWidth:  scr_w_ff     <= csr_wdata;
            tsg_pkg::CsrScreenHeight: scr_h_ff     <= csr_wdata;
            tsg_pkg::CsrMaxJump:      max_jump_ff  <= csr_wdata[tsg_pkg::LimitWidth-1:0];
            tsg_pkg::CsrSwipeMin:     swipe_min_ff <= csr_wdata[tsg_pkg::LimitWidth-1:0];
            default: ;
         endcase
      end
   end

   // Stroke state
   logic                                  active_ff, active_in;
   logic [tsg_pkg::CoordWidth-1:0]        start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [tsg_pkg::CoordWidth-1:0]        prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [tsg_pkg::TravelWidth-1:0] best_x_ff, best_x_in, best_y_ff, best_y_in;

   // Output register and skid register
   tsg_pkg::rsp_word_type out_ff, out_in, skid_ff, skid_in, word;
   logic                  out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic accept, pop;
   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = out_valid_ff && rsp_chan.ready;

   // Decode the report
   logic [tsg_pkg::CoordWidth-1:0] x, y;
   logic                           bad, up;
   assign x  = {req_chan.x_high_byte[3:0], req_chan.x_low_byte};
   assign y  = {req_chan.y_high_byte[3:0], req_chan.y_low_byte};
   assign bad = !req_chan.bus_ok || (req_chan.finger_byte > tsg_pkg::MaxFingers);
   assign up  = (req_chan.finger_byte == 8'd0);

   logic off_screen;
   assign off_screen = ({1'b0, x} >= scr_w_ff) || ({1'b0, y} >= scr_h_ff);

   // Jump from the previous sample and travel from the start
   logic signed [tsg_pkg::TravelWidth-1:0] jx, jy, dx, dy;
   assign jx = $signed({1'b0, x}) - $signed({1'b0, prev_x_ff});
   assign jy = $signed({1'b0, y}) - $signed({1'b0, prev_y_ff});
   assign dx = $signed({1'b0, x}) - $signed({1'b0, start_x_ff});
   assign dy = $signed({1'b0, y}) - $signed({1'b0, start_y_ff});

   logic [tsg_pkg::CoordWidth-1:0] ax, ay;
   logic                           no_glitch, is_swipe;
   assign no_glitch = (tsg_pkg::mag(jx) <= max_jump_ff) && (tsg_pkg::mag(jy) <= max_jump_ff);
   assign ax        = tsg_pkg::mag(best_x_ff);
   assign ay        = tsg_pkg::mag(best_y_ff);
   assign is_swipe  = (ax >= swipe_min_ff) || (ay >= swipe_min_ff);

   always_comb begin
      active_in  = active_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      best_x_in  = best_x_ff;
      best_y_in  = best_y_ff;
      word.sample_class = tsg_pkg::ClassFailed;
      word.gesture      = tsg_pkg::GestNone;

      if (bad) begin
         word.sample_class = tsg_pkg::ClassFailed;
      end else if (up) begin
         word.sample_class = tsg_pkg::ClassUp;
         // Release: resolve the stroke, dominant axis wins, tie goes vertical
         if (active_ff) begin
            active_in = 1'b0;
            if (!is_swipe) begin
               word.gesture = tsg_pkg::GestTap;
            end else if (ax > ay) begin
               word.gesture = (best_x_ff > 0) ? tsg_pkg::GestRight : tsg_pkg::GestLeft;
            end else begin
               word.gesture = (best_y_ff > 0) ? tsg_pkg::GestDown : tsg_pkg::GestUp;
            end
         end
      end else if (off_screen) begin
         word.sample_class = tsg_pkg::ClassFailed;
      end else begin
         word.sample_class = tsg_pkg::ClassDown;
         if (!active_ff) begin
            // First touch latches the start point
            active_in  = 1'b1;
            start_x_in = x;
            start_y_in = y;
            prev_x_in  = x;
            prev_y_in  = y;
            best_x_in  = '0;
            best_y_in  = '0;
         end else if (no_glitch) begin
            prev_x_in = x;
            prev_y_in = y;
            if (tsg_pkg::mag(dx) > ax) best_x_in = dx;
            if (tsg_pkg::mag(dy) > ay) best_y_in = dy;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         start_x_ff <= '0;
         start_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         best_x_ff  <= '0;
         best_y_ff  <= '0;
      end else if (accept) begin
         active_ff  <= active_in;
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
         best_x_ff  <= best_x_in;
         best_y_ff  <= best_y_in;
      end
   end

   // Advance the skid into the output register on a pop; park a new word
   // in the skid only when the output register stays full
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (accept) begin
         if (!out_valid_in) begin
            out_in       = word;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = word;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.sample_class = out_ff.sample_class;
   assign rsp_chan.gesture      = out_ff.gesture;

   // A word never waits in the skid with the output register empty
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a word while output register is empty");

   // Only a release can carry a gesture
   a_gesture_on_release: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.gesture != tsg_pkg::GestNone)
         |-> out_ff.sample_class == tsg_pkg::ClassUp)
      else $error("gesture reported on a word that is not a release");

   // A stroke ends only on an accepted release
   a_stroke_end: assert property (@(posedge clock) disable iff (reset)
      (accept && !active_in && active_ff) |=> !active_ff)
      else $error("stroke did not end on release");

   a_stroke_fall: assert property (@(posedge clock)
      (!reset && $past(!reset) && $fell(active_ff))
         |-> $past(accept && !bad && up))
      else $error("stroke ended without an accepted release");

endmodule

`default_nettype wire

>>> test/tb_touch_swipe_gesture_recognizer_unit.sv
module tb_touch_swipe_gesture_recognizer_unit;

   // Run limits: cycle ceiling, settle time after the last word, receiver hold-off
   localparam int unsigned CycleLimit     = 500000;
   localparam int unsigned SettleCycles   = 6;
   localparam int unsigned HoldAfterWords = 120;
   localparam int unsigned HoldCycles     = 150;
   localparam int unsigned PrintCap       = 200;

   // One polled touch report as offered on the request channel
   typedef struct {
      bit         ok;
      logic [7:0] fingers;
      logic [7:0] xh;
      logic [7:0] xl;
      logic [7:0] yh;
      logic [7:0] yl;
   } touch_report_type;

   // Stroke tracker: mirrors the recogniser state and holds the words still due
   class swipe_scoreboard;
      logic [tsg_pkg::ScreenWidth-1:0]        scr_w, scr_h;
      logic [tsg_pkg::LimitWidth-1:0]         jump_lim, swipe_lim;
      bit                                     in_stroke;
      logic [tsg_pkg::CoordWidth-1:0]         org_x, org_y, last_x, last_y;
      logic signed [tsg_pkg::TravelWidth-1:0] reach_x, reach_y;
      tsg_pkg::rsp_word_type                  due_words[$];
      int unsigned                            fails, words_seen, printed;
      int unsigned                            gesture_tally[8];

      function new();
         scr_w     = tsg_pkg::ScreenWidthReset;
         scr_h     = tsg_pkg::ScreenHeightReset;
         jump_lim  = tsg_pkg::MaxJumpReset;
         swipe_lim = tsg_pkg::SwipeMinReset;
         in_stroke = 1'b0;
         org_x = '0; org_y = '0; last_x = '0; last_y = '0;
         reach_x = '0; reach_y = '0;
         fails = 0; words_seen = 0; printed = 0;
         foreach (gesture_tally[i]) gesture_tally[i] = 0;
      endfunction

      function void write_reg(logic [tsg_pkg::CsrIdxWidth-1:0] idx,
                              logic [tsg_pkg::CsrDataWidth-1:0] val);
         case (idx)
            tsg_pkg::CsrScreenWidth:  scr_w     = val;
            tsg_pkg::CsrScreenHeight: scr_h     = val;
            tsg_pkg::CsrMaxJump:      jump_lim  = val[tsg_pkg::LimitWidth-1:0];
            tsg_pkg::CsrSwipeMin:     swipe_lim = val[tsg_pkg::LimitWidth-1:0];
            default: ;
         endcase
      endfunction

      static function logic [tsg_pkg::TravelWidth-1:0] travel_abs(
         logic signed [tsg_pkg::TravelWidth-1:0] v);
         return v[tsg_pkg::TravelWidth-1] ? -v : v;
      endfunction

      function void note_report(touch_report_type r);
         logic [tsg_pkg::CoordWidth-1:0]         x, y;
         logic signed [tsg_pkg::TravelWidth-1:0] jx, jy, dx, dy;
         logic [tsg_pkg::TravelWidth-1:0]        ax, ay;
         tsg_pkg::rsp_word_type                  w;
         x = {r.xh[3:0], r.xl};
         y = {r.yh[3:0], r.yl};
         w.sample_class = tsg_pkg::ClassFailed;
         w.gesture      = tsg_pkg::GestNone;
         if (!r.ok || r.fingers > tsg_pkg::MaxFingers) begin
            // failed read: leave the stroke alone
         end else if (r.fingers == 8'd0) begin
            w.sample_class = tsg_pkg::ClassUp;
            if (in_stroke) begin
               in_stroke = 1'b0;
               ax = travel_abs(reach_x);
               ay = travel_abs(reach_y);
               if (ax >= {1'b0, swipe_lim} || ay >= {1'b0, swipe_lim}) begin
                  if (ax > ay)
                     w.gesture = (!reach_x[tsg_pkg::TravelWidth-1] && reach_x != 0) ?
                                 tsg_pkg::GestRight : tsg_pkg::GestLeft;
                  else
                     w.gesture = (!reach_y[tsg_pkg::TravelWidth-1] && reach_y != 0) ?
                                 tsg_pkg::GestDown : tsg_pkg::GestUp;
               end else begin
                  w.gesture = tsg_pkg::GestTap;
               end
            end
         end else if ({1'b0, x} >= scr_w || {1'b0, y} >= scr_h) begin
            // touched point off the screen counts as a failed read
         end else begin
            w.sample_class = tsg_pkg::ClassDown;
            if (!in_stroke) begin
               in_stroke = 1'b1;
               org_x = x; org_y = y;
               last_x = x; last_y = y;
               reach_x = '0; reach_y = '0;
            end else begin
               jx = $signed({1'b0, x}) - $signed({1'b0, last_x});
               jy = $signed({1'b0, y}) - $signed({1'b0, last_y});
               if (travel_abs(jx) <= {1'b0, jump_lim} && travel_abs(jy) <= {1'b0, jump_lim}) begin
                  dx = $signed({1'b0, x}) - $signed({1'b0, org_x});
                  dy = $signed({1'b0, y}) - $signed({1'b0, org_y});
                  last_x = x; last_y = y;
                  if (travel_abs(dx) > travel_abs(reach_x)) reach_x = dx;
                  if (travel_abs(dy) > travel_abs(reach_y)) reach_y = dy;
               end
            end
         end
         due_words.push_back(w);
      endfunction

      function void check_word(logic [1:0] cls, logic [2:0] gest);
         tsg_pkg::rsp_word_type w;
         words_seen++;
         if (due_words.size() == 0) begin
            fails++;
            if (printed < PrintCap) begin
               printed++;
               $display("%0t: unexpected word: expected none, got class %0d gesture %0d",
                        $time, cls, gest);
            end
            return;
         end
         w = due_words.pop_front();
         gesture_tally[w.gesture]++;
         if (cls !== w.sample_class || gest !== w.gesture) begin
            fails++;
            if (printed < PrintCap) begin
               printed++;
               $display("%0t: word %0d: expected class %0d gesture %0d, got class %0d gesture %0d",
                        $time, words_seen, w.sample_class, w.gesture, cls, gest);
            end
         end
      endfunction

      function int pending();
         return due_words.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                             csr_we;
   logic [tsg_pkg::CsrIdxWidth-1:0]  csr_index;
   logic [tsg_pkg::CsrDataWidth-1:0] csr_wdata;

   tsg_req_if req_bus ();
   tsg_rsp_if rsp_bus ();

   touch_swipe_gesture_recognizer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   swipe_scoreboard  sb;
   touch_report_type reports_to_send[$];
   int unsigned      sent_count;
   int unsigned      setting_count;
   int unsigned      cycle_count;
   // Per-side idling state: index 0 is the sender, 1 the receiver
   int unsigned      idle_run[2];
   bit               idle_calm[2];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: end the run with a failure once the cycle count passes CycleLimit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Draw the wait before the next word; long calm stretches keep full rate
   function automatic int unsigned draw_gap(int side);
      if (idle_run[side] == 0) begin
         idle_run[side]  = $urandom_range(16, 80);
         idle_calm[side] = ($urandom_range(0, 3) == 0);
      end
      idle_run[side]--;
      return idle_calm[side] ? 0 : $urandom_range(0, 7);
   endfunction

   // Build a report; the high nibbles of the high bytes are junk the block must ignore
   function automatic touch_report_type make_report(bit ok, logic [7:0] fingers,
                                                    logic [11:0] x, logic [11:0] y);
      touch_report_type r;
      r.ok      = ok;
      r.fingers = fingers;
      r.xh      = 8'($urandom);
      r.xh[3:0] = x[11:8];
      r.xl      = x[7:0];
      r.yh      = 8'($urandom);
      r.yh[3:0] = y[11:8];
      r.yl      = y[7:0];
      return r;
   endfunction

   // Failed bus read, bad finger count, or raw random bits
   function automatic touch_report_type noise_report();
      touch_report_type r;
      r = make_report(1'b0, 8'($urandom), 12'($urandom), 12'($urandom));
      case ($urandom_range(0, 2))
         0: ;
         1: begin
            r.ok      = 1'b1;
            r.fingers = 8'($urandom_range(3, 255));
         end
         default: r.ok = 1'($urandom);
      endcase
      return r;
   endfunction

   function automatic int clamp(int v, int hi);
      return (v < 0) ? 0 : ((v > hi) ? hi : v);
   endfunction

   function automatic int pick_screen();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(64, 1024);
   endfunction

   // Queue strokes with random content: drifting walks, glitches, off-screen points,
   // failed reads in the middle, and stray noise between strokes
   task automatic build_strokes(int count);
      int lim_x, lim_y, cap, n, len, k, px, py, vx, vy, qx;
      lim_x = (sb.scr_w == 0 || sb.scr_w > 4096) ? 4096 : int'(sb.scr_w);
      lim_y = (sb.scr_h == 0 || sb.scr_h > 4096) ? 4096 : int'(sb.scr_h);
      cap   = (sb.jump_lim < 48) ? int'(sb.jump_lim) : 48;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 5) == 0) begin
            reports_to_send.push_back(noise_report());
            n++;
         end else begin
            px  = $urandom_range(0, lim_x - 1);
            py  = $urandom_range(0, lim_y - 1);
            vx  = int'($urandom_range(0, 2)) - 1;
            vy  = int'($urandom_range(0, 2)) - 1;
            len = $urandom_range(1, 12);
            reports_to_send.push_back(make_report(1'b1, 8'($urandom_range(1, 2)),
                                                  12'(px), 12'(py)));
            for (k = 1; k < len; k++) begin
               case ($urandom_range(0, 11))
                  0: begin
                     // jump past the glitch limit; the previous point must hold
                     qx = px + ((vx < 0) ? -1 : 1) * (int'(sb.jump_lim) + $urandom_range(1, 64));
                     reports_to_send.push_back(make_report(1'b1, 8'($urandom_range(1, 2)),
                                                           12'(clamp(qx, 4095)), 12'(py)));
                  end
                  1: reports_to_send.push_back(noise_report());
                  2: begin
                     if (lim_x < 4096)
                        reports_to_send.push_back(make_report(1'b1, 8'd1,
                                                  12'($urandom_range(lim_x, 4095)), 12'(py)));
                     else
                        reports_to_send.push_back(noise_report());
                  end
                  default: begin
                     px = px + vx * int'($urandom_range(0, cap));
                     py = py + vy * int'($urandom_range(0, cap));
                     if ($urandom_range(0, 3) == 0) px = px + int'($urandom_range(0, 2 * cap)) - cap;
                     if ($urandom_range(0, 3) == 0) py = py + int'($urandom_range(0, 2 * cap)) - cap;
                     px = clamp(px, lim_x - 1);
                     py = clamp(py, lim_y - 1);
                     reports_to_send.push_back(make_report(1'b1, 8'($urandom_range(1, 2)),
                                                           12'(px), 12'(py)));
                  end
               endcase
            end
            // release; coordinates are not looked at with no finger down
            reports_to_send.push_back(make_report(1'b1, 8'd0, 12'($urandom), 12'($urandom)));
            n += len + 1;
         end
      end
   endtask

   // Offer every queued report; hold each word until the block takes it
   task automatic offer_reports();
      touch_report_type r;
      int unsigned      gap;
      while (reports_to_send.size() != 0) begin
         r   = reports_to_send.pop_front();
         gap = draw_gap(0);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_bus.bus_ok      <= r.ok;
         req_bus.finger_byte <= r.fingers;
         req_bus.x_high_byte <= r.xh;
         req_bus.x_low_byte  <= r.xl;
         req_bus.y_high_byte <= r.yh;
         req_bus.y_low_byte  <= r.yl;
         req_bus.valid       <= 1'b1;
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
         sb.note_report(r);
         sent_count++;
      end
      req_bus.valid <= 1'b0;
   endtask

   // Sink side: random back-pressure, plus one long hold-off so the block fills up
   task automatic receive_words();
      int unsigned gap;
      bit          held;
      held = 1'b0;
      forever begin
         gap = draw_gap(1);
         if (!held && sb.words_seen >= HoldAfterWords) begin
            held = 1'b1;
            gap  = HoldCycles;
         end
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         sb.check_word(rsp_bus.sample_class, rsp_bus.gesture);
      end
   endtask

   // Drain outstanding words, then let the pipeline settle
   task automatic wait_idle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Write one register at this edge; leave the enable high for a following write
   task automatic csr_put(logic [tsg_pkg::CsrIdxWidth-1:0] idx, int val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= tsg_pkg::CsrDataWidth'(val);
      @(posedge clock);
      sb.write_reg(idx, tsg_pkg::CsrDataWidth'(val));
   endtask

   task automatic run_phase(int w, int h, int j, int s, int items);
      wait_idle();
      csr_put(tsg_pkg::CsrScreenWidth, w);
      csr_put(tsg_pkg::CsrScreenHeight, h);
      csr_put(tsg_pkg::CsrMaxJump, j);
      csr_put(tsg_pkg::CsrSwipeMin, s);
      csr_we <= 1'b0;
      setting_count++;
      build_strokes(items);
      offer_reports();
   endtask

   // Hand-picked reports under the reset settings (240 x 240, jump 40, swipe 30)
   task automatic load_directed();
      reports_to_send.push_back(make_report(1'b0, 8'd1, 12'd10, 12'd10));      // bus failure
      reports_to_send.push_back(make_report(1'b1, 8'd3, 12'd10, 12'd10));      // too many fingers
      reports_to_send.push_back(make_report(1'b1, 8'd255, 12'd4095, 12'd4095));
      reports_to_send.push_back(make_report(1'b1, 8'd0, 12'd0, 12'd0));        // release, no stroke
      reports_to_send.push_back(make_report(1'b1, 8'd1, 12'd240, 12'd10));     // x on the edge
      reports_to_send.push_back(make_report(1'b1, 8'd1, 12'd10, 12'd240));     // y on the edge
      // tap
      reports_to_send.push_back(make_report(1'b1, 8'd1, 12'd100, 12'd100));
      reports_to_send.push_back(make_report(1'b1, 8'd2, 12'd105, 12'd102));
      reports_to_send.push_back(make_report(1'b1, 8'd0, 12'd0, 12'd0));
      // swipe right
      reports_to_send.push_back(make_report(1'b1, 8'd1, 12'd100, 12'd100));
      reports_to_send.push_back(make_report(1'b1, 8'd1, 12'd135, 12'd100));
      reports_to_send.push_back(make_report(1'b1, 8'd0, 12'd4095, 12'd4095));
      // swipe left
      reports_to_send.push_back(make_report(1'b1, 8'd1, 12'd100, 12'd100));
      reports_to_send.push_back(make_report(1'b1, 8'd2, 12'd65, 12'd110));
      reports_to_send.push_back(make_report(1'b1, 8'd0, 12'd0, 12'd0));
      // swipe up, exactly at the threshold
      reports_to_send.push_back(make_report(1'b1, 8'd1, 12'd100, 12'd100));
      reports_to_send.push_back(make_report(1'b1, 8'd1, 12'd100, 12'd70));
      reports_to_send.push_back(make_report(1'b1, 8'd0, 12'd0, 12'd0));
      // glitch dropped, then a diagonal tie that resolves downwards
      reports_to_send.push_back(make_report(1'b1, 8'd1, 12'd100, 12'd100));
      reports_to_send.push_back(make_report(1'b1, 8'd1, 12'd141, 12'd100));
      reports_to_send.push_back(make_report(1'b1, 8'd1, 12'd130, 12'd130));
      reports_to_send.push_back(make_report(1'b1, 8'd1, 12'd239, 12'd239));
      reports_to_send.push_back(make_report(1'b0, 8'd0, 12'd0, 12'd0));        // failed mid-stroke
      reports_to_send.push_back(make_report(1'b1, 8'd0, 12'd0, 12'd0));
      // stroke at the origin corner
      reports_to_send.push_back(make_report(1'b1, 8'd2, 12'd0, 12'd0));
      reports_to_send.push_back(make_report(1'b1, 8'd0, 12'd0, 12'd0));
   endtask

   initial begin
      sb            = new();
      sent_count    = 0;
      setting_count = 0;
      cycle_count   = 0;
      idle_run[0]   = 0;
      idle_run[1]   = 0;
      idle_calm[0]  = 1'b0;
      idle_calm[1]  = 1'b0;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.bus_ok      = 1'b0;
      req_bus.finger_byte = '0;
      req_bus.x_high_byte = '0;
      req_bus.x_low_byte  = '0;
      req_bus.y_high_byte = '0;
      req_bus.y_low_byte  = '0;
      rsp_bus.ready       = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      fork
         receive_words();
      join_none

      load_directed();
      offer_reports();

      // extremes first: everything a swipe, a one-pixel screen, a zero-size screen
      run_phase(4096, 4096, 4095, 0, 200);
      run_phase(1, 1, 0, 4095, 100);
      run_phase(0, 0, 40, 30, 40);
      run_phase(240, 240, 40, 30, 300);
      repeat (4)
         run_phase(pick_screen(), pick_screen(),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 80),
                   $urandom_range(0, 160), 300);

      wait_idle();
      if (sb.pending() != 0) begin
         sb.fails++;
         $display("%0t: %0d words still expected at the end", $time, sb.pending());
      end
      $display("tb: %0d reports sent, %0d words checked over %0d register settings",
               sent_count, sb.words_seen, setting_count);
      $display("tb: gestures tap %0d up %0d down %0d left %0d right %0d, mismatches %0d",
               sb.gesture_tally[tsg_pkg::GestTap], sb.gesture_tally[tsg_pkg::GestUp],
               sb.gesture_tally[tsg_pkg::GestDown], sb.gesture_tally[tsg_pkg::GestLeft],
               sb.gesture_tally[tsg_pkg::GestRight], sb.fails);
      if (sb.fails == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> sim.f
sv/tsg_pkg.sv
sv/tsg_req_if.sv
sv/tsg_rsp_if.sv
sv/touch_swipe_gesture_recognizer_unit.sv
test/tb_touch_swipe_gesture_recognizer_unit.sv
